// ----- rtl/core/sev_pkg.sv -----
// Shared types and constants of the satellite elevation visibility test.
// Used by sev_front, sev_cmp, satellite_elevation_visibility_test_core, sev_checker and tb.
// No dependencies.
package sev_pkg;

  // Coordinate and sine formats
  localparam int COORD_W   = 27;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SINE_W    = 16;
  localparam int SINE_FRAC = SINE_W - 1;

  // Widths of the squared lengths and of the dot product
  localparam int SQ_W   = 2 * COORD_W;
  localparam int D2_W   = 2 * DIFF_W;
  localparam int PROD_W = COORD_W + DIFF_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int DMAG_W = DOT_W - 1;
  localparam int S2_W   = 2 * SINE_W - 1;

  // Limb split of the wide products
  localparam int LIMB_W = 32;
  localparam int DH_W   = DMAG_W - LIMB_W;
  localparam int STH_W  = SQ_W - LIMB_W;
  localparam int D2H_W  = D2_W - LIMB_W;
  localparam int SS_W   = S2_W + SQ_W;
  localparam int SSH_W  = SS_W - 2 * LIMB_W;
  localparam int DOT2_W = 2 * DMAG_W;
  localparam int R0_W   = SS_W + LIMB_W;
  localparam int R1_W   = SS_W + D2H_W;
  localparam int RHS_W  = SS_W + D2_W;
  localparam int CMP_W  = DOT2_W + 2 * SINE_FRAC;

  // Earth equatorial radius squared, in square metres
  localparam logic [SQ_W-1:0] EARTH_R2 = SQ_W'(64'd6378137 * 64'd6378137);

  // Station reset position
  localparam logic [COORD_W-1:0] STATION_X_RST = COORD_W'(6378137);

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = COORD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATION_X = 8'd0,
    CFG_STATION_Y = 8'd1,
    CFG_STATION_Z = 8'd2,
    CFG_MIN_SINE  = 8'd3
  } cfg_reg_t;

  // Outcome known before the wide compare, or which compare decides it
  typedef enum logic [1:0] {
    DEC_FALSE,
    DEC_TRUE,
    DEC_GE,
    DEC_LE
  } decide_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t              station;
    logic [SINE_W-1:0] sine;
  } cfg_t;

  // Geometry handed from the front end to the wide compare
  typedef struct packed {
    logic              dead;
    decide_t           decision;
    logic [DMAG_W-1:0] dot_mag;
    logic [S2_W-1:0]   sine_sq;
    logic [SQ_W-1:0]   st2;
    logic [D2_W-1:0]   d2;
  } geom_t;

endpackage

// ----- rtl/core/sev_front.sv -----
// Front end of the visibility test: difference vector, squares, dot product
// and classification, four register stages. Depends on sev_pkg.
module sev_front #(
  parameter int IDX_W = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sev_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   in_idx,
  input  sev_pkg::vec_t      in_sat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_idx,
  output sev_pkg::geom_t     out_geom
);
  import sev_pkg::*;

  logic en_a, en_b, en_c, en_d;
  logic v_a_r, v_b_r, v_c_r, v_d_r;
  logic v_a_nxt, v_b_nxt, v_c_nxt, v_d_nxt;

  logic signed [COORD_W-1:0] sat_in [3];
  logic signed [COORD_W-1:0] st_in [3];

  // Stage A registers
  logic [IDX_W-1:0]          idx_a_r;
  logic signed [COORD_W-1:0] sat_a_r [3];
  logic signed [DIFF_W-1:0]  d_a_r [3];
  logic signed [DIFF_W-1:0]  d_a_nxt [3];

  // Stage B registers
  logic [IDX_W-1:0]          idx_b_r;
  logic signed [SQ_W-1:0]    sat_sq_nxt [3];
  logic signed [SQ_W-1:0]    st_sq_nxt [3];
  logic signed [D2_W-1:0]    d_sq_nxt [3];
  logic signed [PROD_W-1:0]  dot_p_nxt [3];
  logic signed [SQ_W-1:0]    sat_sq_r [3];
  logic signed [SQ_W-1:0]    st_sq_r [3];
  logic signed [D2_W-1:0]    d_sq_r [3];
  logic signed [PROD_W-1:0]  dot_p_r [3];
  logic signed [2*SINE_W-1:0] s_sq_full;
  logic [S2_W-1:0]           s2_b_r;

  // Stage C registers
  logic [IDX_W-1:0]          idx_c_r;
  logic [SQ_W-1:0]           sat2_c_r, sat2_c_nxt;
  logic [SQ_W-1:0]           st2_c_r, st2_c_nxt;
  logic [D2_W-1:0]           d2_c_r, d2_c_nxt;
  logic signed [DOT_W-1:0]   dot_c_r, dot_c_nxt;
  logic [S2_W-1:0]           s2_c_r;

  // Stage D registers
  logic [IDX_W-1:0]          idx_d_r;
  geom_t                     geom_d_r, geom_d_nxt;
  logic [DOT_W-1:0]          dot_neg_val;
  logic                      dot_neg, sine_pos, zero_len, dead_c;

  // Stall chain: a stage loads when it is empty or its successor moves on
  assign en_d     = !v_d_r || out_ready;
  assign en_c     = !v_c_r || en_d;
  assign en_b     = !v_b_r || en_c;
  assign en_a     = !v_a_r || en_b;
  assign in_ready = en_a;

  assign v_a_nxt = en_a ? in_valid : v_a_r;
  assign v_b_nxt = en_b ? v_a_r : v_b_r;
  assign v_c_nxt = en_c ? v_b_r : v_c_r;
  assign v_d_nxt = en_d ? v_c_r : v_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_b_nxt;
      v_c_r <= v_c_nxt;
      v_d_r <= v_d_nxt;
    end
  end

  // Axis views of the request and the station
  assign sat_in[0] = $signed(in_sat.x);
  assign sat_in[1] = $signed(in_sat.y);
  assign sat_in[2] = $signed(in_sat.z);
  assign st_in[0]  = $signed(cfg.station.x);
  assign st_in[1]  = $signed(cfg.station.y);
  assign st_in[2]  = $signed(cfg.station.z);

  // Per-axis difference, then squares and dot product terms
  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign d_a_nxt[k]    = DIFF_W'(sat_in[k]) - DIFF_W'(st_in[k]);
    assign sat_sq_nxt[k] = sat_a_r[k] * sat_a_r[k];
    assign st_sq_nxt[k]  = st_in[k] * st_in[k];
    assign d_sq_nxt[k]   = d_a_r[k] * d_a_r[k];
    assign dot_p_nxt[k]  = st_in[k] * d_a_r[k];
  end

  assign s_sq_full = $signed(cfg.sine) * $signed(cfg.sine);

  // Stage A: difference vector
  always_ff @(posedge clk) begin
    if (en_a) begin
      idx_a_r <= in_idx;
      for (int k = 0; k < 3; k++) begin
        sat_a_r[k] <= sat_in[k];
        d_a_r[k]   <= d_a_nxt[k];
      end
    end
  end

  // Stage B: products
  always_ff @(posedge clk) begin
    if (en_b) begin
      idx_b_r <= idx_a_r;
      s2_b_r  <= s_sq_full[S2_W-1:0];
      for (int k = 0; k < 3; k++) begin
        sat_sq_r[k] <= sat_sq_nxt[k];
        st_sq_r[k]  <= st_sq_nxt[k];
        d_sq_r[k]   <= d_sq_nxt[k];
        dot_p_r[k]  <= dot_p_nxt[k];
      end
    end
  end

  // Stage C: sums over the three axes
  assign sat2_c_nxt = $unsigned(sat_sq_r[0]) + $unsigned(sat_sq_r[1])
                    + $unsigned(sat_sq_r[2]);
  assign st2_c_nxt  = $unsigned(st_sq_r[0]) + $unsigned(st_sq_r[1])
                    + $unsigned(st_sq_r[2]);
  assign d2_c_nxt   = $unsigned(d_sq_r[0]) + $unsigned(d_sq_r[1])
                    + $unsigned(d_sq_r[2]);
  assign dot_c_nxt  = DOT_W'(dot_p_r[0]) + DOT_W'(dot_p_r[1]) + DOT_W'(dot_p_r[2]);

  always_ff @(posedge clk) begin
    if (en_c) begin
      idx_c_r  <= idx_b_r;
      sat2_c_r <= sat2_c_nxt;
      st2_c_r  <= st2_c_nxt;
      d2_c_r   <= d2_c_nxt;
      dot_c_r  <= dot_c_nxt;
      s2_c_r   <= s2_b_r;
    end
  end

  // Stage D: dead test, sign handling and choice of the final compare
  assign dead_c      = sat2_c_r < EARTH_R2;
  assign zero_len    = (st2_c_r == '0) || (d2_c_r == '0);
  assign dot_neg     = dot_c_r[DOT_W-1];
  assign dot_neg_val = -dot_c_r;
  assign sine_pos    = !cfg.sine[SINE_W-1] && (cfg.sine != '0);

  always_comb begin
    geom_d_nxt.dead    = dead_c;
    geom_d_nxt.dot_mag = dot_neg ? dot_neg_val[DMAG_W-1:0] : dot_c_r[DMAG_W-1:0];
    geom_d_nxt.sine_sq = s2_c_r;
    geom_d_nxt.st2     = st2_c_r;
    geom_d_nxt.d2      = d2_c_r;
    if (dead_c || zero_len) begin
      geom_d_nxt.decision = DEC_FALSE;
    end else if (!dot_neg && !sine_pos) begin
      geom_d_nxt.decision = DEC_TRUE;
    end else if (dot_neg && sine_pos) begin
      geom_d_nxt.decision = DEC_FALSE;
    end else if (dot_neg) begin
      geom_d_nxt.decision = DEC_LE;
    end else begin
      geom_d_nxt.decision = DEC_GE;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      idx_d_r  <= idx_c_r;
      geom_d_r <= geom_d_nxt;
    end
  end

  assign out_valid = v_d_r;
  assign out_idx   = idx_d_r;
  assign out_geom  = geom_d_r;

`ifndef ASSERT_OFF
  // Input is refused only when every stage holds a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_a_r && v_b_r && v_c_r && v_d_r))
    else $error("sev_front: input refused with a free stage");

  // A dead satellite is never sent on to the wide compare as a candidate.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_d_r && geom_d_r.dead) |-> (geom_d_r.decision == DEC_FALSE))
    else $error("sev_front: dead satellite not decided false");
`endif

endmodule

// ----- rtl/core/sev_cmp.sv -----
// Wide compare of the visibility test: dot^2 * 2^(2F) against
// sine^2 * |station|^2 * |d|^2, split into 32-bit limbs over six stages.
// Depends on sev_pkg.
module sev_cmp #(
  parameter int IDX_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_idx,
  input  sev_pkg::geom_t   in_geom,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_idx,
  output logic             out_visible,
  output logic             out_dead
);
  import sev_pkg::*;

  logic en_e, en_f, en_g, en_h, en_i, en_j;
  logic v_e_r, v_f_r, v_g_r, v_h_r, v_i_r, v_j_r;
  logic v_e_nxt, v_f_nxt, v_g_nxt, v_h_nxt, v_i_nxt, v_j_nxt;

  // Item tags carried along every stage
  logic [IDX_W-1:0] idx_e_r, idx_f_r, idx_g_r, idx_h_r, idx_i_r, idx_j_r;
  logic             dead_e_r, dead_f_r, dead_g_r, dead_h_r, dead_i_r, dead_j_r;
  decide_t          dec_e_r, dec_f_r, dec_g_r, dec_h_r, dec_i_r;

  // Stage E: first partial products
  logic [2*LIMB_W-1:0]     pll_nxt, pll_e_r;
  logic [LIMB_W+DH_W-1:0]  plh_nxt, plh_e_r;
  logic [2*DH_W-1:0]       phh_nxt, phh_e_r;
  logic [S2_W+LIMB_W-1:0]  q0_nxt, q0_e_r;
  logic [S2_W+STH_W-1:0]   q1_nxt, q1_e_r;
  logic [D2_W-1:0]         d2_e_r, d2_f_r;

  // Stage F: dot squared and sine^2 * |station|^2
  logic [DOT2_W-1:0]       dot2_nxt, dot2_f_r, dot2_g_r, dot2_h_r, dot2_i_r;
  logic [SS_W-1:0]         ss_nxt, ss_f_r;

  // Stage G: second partial products
  logic [2*LIMB_W-1:0]      m00_nxt, m10_nxt, m00_g_r, m10_g_r;
  logic [SSH_W+LIMB_W-1:0]  m20_nxt, m20_g_r;
  logic [LIMB_W+D2H_W-1:0]  m01_nxt, m11_nxt, m01_g_r, m11_g_r;
  logic [SSH_W+D2H_W-1:0]   m21_nxt, m21_g_r;

  // Stage H and I: accumulation of the right-hand side
  logic [R0_W-1:0]  r0_nxt, r0_h_r;
  logic [R1_W-1:0]  r1_nxt, r1_h_r;
  logic [RHS_W-1:0] rhs_nxt, rhs_i_r;

  // Stage J: final compare
  logic [CMP_W-1:0] lhs_cmp, rhs_cmp;
  logic             vis_nxt, vis_j_r;

  // Stall chain
  assign en_j     = !v_j_r || out_ready;
  assign en_i     = !v_i_r || en_j;
  assign en_h     = !v_h_r || en_i;
  assign en_g     = !v_g_r || en_h;
  assign en_f     = !v_f_r || en_g;
  assign en_e     = !v_e_r || en_f;
  assign in_ready = en_e;

  assign v_e_nxt = en_e ? in_valid : v_e_r;
  assign v_f_nxt = en_f ? v_e_r : v_f_r;
  assign v_g_nxt = en_g ? v_f_r : v_g_r;
  assign v_h_nxt = en_h ? v_g_r : v_h_r;
  assign v_i_nxt = en_i ? v_h_r : v_i_r;
  assign v_j_nxt = en_j ? v_i_r : v_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
      v_g_r <= 1'b0;
      v_h_r <= 1'b0;
      v_i_r <= 1'b0;
      v_j_r <= 1'b0;
    end else begin
      v_e_r <= v_e_nxt;
      v_f_r <= v_f_nxt;
      v_g_r <= v_g_nxt;
      v_h_r <= v_h_nxt;
      v_i_r <= v_i_nxt;
      v_j_r <= v_j_nxt;
    end
  end

  // Stage E: split |dot| and |station|^2 into limbs and multiply
  assign pll_nxt = in_geom.dot_mag[LIMB_W-1:0] * in_geom.dot_mag[LIMB_W-1:0];
  assign plh_nxt = in_geom.dot_mag[LIMB_W-1:0] * in_geom.dot_mag[DMAG_W-1:LIMB_W];
  assign phh_nxt = in_geom.dot_mag[DMAG_W-1:LIMB_W] * in_geom.dot_mag[DMAG_W-1:LIMB_W];
  assign q0_nxt  = in_geom.sine_sq * in_geom.st2[LIMB_W-1:0];
  assign q1_nxt  = in_geom.sine_sq * in_geom.st2[SQ_W-1:LIMB_W];

  always_ff @(posedge clk) begin
    if (en_e) begin
      idx_e_r  <= in_idx;
      dead_e_r <= in_geom.dead;
      dec_e_r  <= in_geom.decision;
      pll_e_r  <= pll_nxt;
      plh_e_r  <= plh_nxt;
      phh_e_r  <= phh_nxt;
      q0_e_r   <= q0_nxt;
      q1_e_r   <= q1_nxt;
      d2_e_r   <= in_geom.d2;
    end
  end

  // Stage F: add up the partial products
  assign dot2_nxt = DOT2_W'(pll_e_r) + (DOT2_W'(plh_e_r) << (LIMB_W + 1))
                  + (DOT2_W'(phh_e_r) << (2 * LIMB_W));
  assign ss_nxt   = SS_W'(q0_e_r) + (SS_W'(q1_e_r) << LIMB_W);

  always_ff @(posedge clk) begin
    if (en_f) begin
      idx_f_r  <= idx_e_r;
      dead_f_r <= dead_e_r;
      dec_f_r  <= dec_e_r;
      dot2_f_r <= dot2_nxt;
      ss_f_r   <= ss_nxt;
      d2_f_r   <= d2_e_r;
    end
  end

  // Stage G: limb products of (sine^2 * |station|^2) by |d|^2
  assign m00_nxt = ss_f_r[LIMB_W-1:0] * d2_f_r[LIMB_W-1:0];
  assign m10_nxt = ss_f_r[2*LIMB_W-1:LIMB_W] * d2_f_r[LIMB_W-1:0];
  assign m20_nxt = ss_f_r[SS_W-1:2*LIMB_W] * d2_f_r[LIMB_W-1:0];
  assign m01_nxt = ss_f_r[LIMB_W-1:0] * d2_f_r[D2_W-1:LIMB_W];
  assign m11_nxt = ss_f_r[2*LIMB_W-1:LIMB_W] * d2_f_r[D2_W-1:LIMB_W];
  assign m21_nxt = ss_f_r[SS_W-1:2*LIMB_W] * d2_f_r[D2_W-1:LIMB_W];

  always_ff @(posedge clk) begin
    if (en_g) begin
      idx_g_r  <= idx_f_r;
      dead_g_r <= dead_f_r;
      dec_g_r  <= dec_f_r;
      dot2_g_r <= dot2_f_r;
      m00_g_r  <= m00_nxt;
      m10_g_r  <= m10_nxt;
      m20_g_r  <= m20_nxt;
      m01_g_r  <= m01_nxt;
      m11_g_r  <= m11_nxt;
      m21_g_r  <= m21_nxt;
    end
  end

  // Stage H: sum per limb of |d|^2
  assign r0_nxt = R0_W'(m00_g_r) + (R0_W'(m10_g_r) << LIMB_W)
                + (R0_W'(m20_g_r) << (2 * LIMB_W));
  assign r1_nxt = R1_W'(m01_g_r) + (R1_W'(m11_g_r) << LIMB_W)
                + (R1_W'(m21_g_r) << (2 * LIMB_W));

  always_ff @(posedge clk) begin
    if (en_h) begin
      idx_h_r  <= idx_g_r;
      dead_h_r <= dead_g_r;
      dec_h_r  <= dec_g_r;
      dot2_h_r <= dot2_g_r;
      r0_h_r   <= r0_nxt;
      r1_h_r   <= r1_nxt;
    end
  end

  // Stage I: full right-hand side
  assign rhs_nxt = RHS_W'(r0_h_r) + (RHS_W'(r1_h_r) << LIMB_W);

  always_ff @(posedge clk) begin
    if (en_i) begin
      idx_i_r  <= idx_h_r;
      dead_i_r <= dead_h_r;
      dec_i_r  <= dec_h_r;
      dot2_i_r <= dot2_h_r;
      rhs_i_r  <= rhs_nxt;
    end
  end

  // Stage J: compare and resolve the result; this is the output register
  assign lhs_cmp = CMP_W'(dot2_i_r) << (2 * SINE_FRAC);
  assign rhs_cmp = CMP_W'(rhs_i_r);

  always_comb begin
    case (dec_i_r)
      DEC_TRUE:  vis_nxt = 1'b1;
      DEC_FALSE: vis_nxt = 1'b0;
      DEC_GE:    vis_nxt = lhs_cmp >= rhs_cmp;
      DEC_LE:    vis_nxt = lhs_cmp <= rhs_cmp;
      default:   vis_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_j) begin
      idx_j_r  <= idx_i_r;
      dead_j_r <= dead_i_r;
      vis_j_r  <= vis_nxt;
    end
  end

  assign out_valid   = v_j_r;
  assign out_idx     = idx_j_r;
  assign out_visible = vis_j_r;
  assign out_dead    = dead_j_r;

`ifndef ASSERT_OFF
  // A dead satellite is never reported visible.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_j_r && dead_j_r) |-> !vis_j_r)
    else $error("sev_cmp: dead satellite reported visible");

  // A request decided true up front comes out visible.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_i_r && en_j && (dec_i_r == DEC_TRUE)) |=> (v_j_r && vis_j_r))
    else $error("sev_cmp: early true decision lost");
`endif

endmodule

// ----- rtl/core/satellite_elevation_visibility_test_core.sv -----
// Top level of the satellite elevation visibility test: configuration
// registers, port packing and the two pipeline sections.
// Depends on sev_pkg, sev_front and sev_cmp.
//
// Usage:
//   in_*  : one request per satellite: index and ECEF position in metres.
//   out_* : one result per request, in order: index, visible flag, dead flag.
//   cfg_* : register writes (station x, y, z and sine of minimum elevation,
//           Q1.15). Writes are always taken; write only while no request is
//           in flight. Unknown register indexes are ignored.
// An accepted request passes to its result on out_tvalid through four stages
// of difference, squares, sums and sign classification, then six stages of
// limb multiplies and adds ending in the wide compare, whose last stage is
// the output register. One request is accepted per cycle while in_tready is high.
// When the receiver stalls, each stage keeps its request and empty stages
// further up keep filling; in_tready falls only once all ten stages are full.
// Reset (rst_n low, synchronous) empties the pipeline and puts the station at
// (6378137, 0, 0) with a minimum elevation sine of zero.
module satellite_elevation_visibility_test_core #(
  parameter int MAX_SATELLITES = 4096,
  localparam int IDX_W = $clog2(MAX_SATELLITES),
  localparam int IN_W  = ((IDX_W + 3 * sev_pkg::COORD_W + 7) / 8) * 8,
  localparam int OUT_W = ((IDX_W + 2 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: sat_index, sat_x, sat_y, sat_z, zero padding
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,
  // out_tdata: result_index, visible, dead, zero padding
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sev_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sev_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sev_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  logic [IDX_W-1:0] in_idx;
  vec_t             in_sat;

  logic             mid_valid, mid_ready;
  logic [IDX_W-1:0] mid_idx;
  geom_t            mid_geom;

  logic [IDX_W-1:0] res_idx;
  logic             res_visible, res_dead;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_STATION_X: cfg_nxt.station.x = cfg_data[COORD_W-1:0];
        CFG_STATION_Y: cfg_nxt.station.y = cfg_data[COORD_W-1:0];
        CFG_STATION_Z: cfg_nxt.station.z = cfg_data[COORD_W-1:0];
        CFG_MIN_SINE:  cfg_nxt.sine      = cfg_data[SINE_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station.x <= STATION_X_RST;
      cfg_r.station.y <= '0;
      cfg_r.station.z <= '0;
      cfg_r.sine      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Unpack the request
  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_sat.x = in_tdata[IDX_W +: COORD_W];
  assign in_sat.y = in_tdata[IDX_W + COORD_W +: COORD_W];
  assign in_sat.z = in_tdata[IDX_W + 2 * COORD_W +: COORD_W];

  // Difference, squares and classification
  sev_front #(.IDX_W(IDX_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_idx    (in_idx),
    .in_sat    (in_sat),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_idx   (mid_idx),
    .out_geom  (mid_geom)
  );

  // Wide compare and output register
  sev_cmp #(.IDX_W(IDX_W)) u_cmp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (mid_valid),
    .in_ready    (mid_ready),
    .in_idx      (mid_idx),
    .in_geom     (mid_geom),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_idx     (res_idx),
    .out_visible (res_visible),
    .out_dead    (res_dead)
  );

  // Pack the result
  assign out_tdata = OUT_W'({res_dead, res_visible, res_idx});

endmodule

// ----- sim/sev_checker.sv -----
// Checker for the satellite elevation visibility test: watches the request,
// result and register-write channels, predicts each result and compares it.
// Depends on sev_pkg for the coordinate widths and register indexes.
module sev_checker #(
  parameter int IDX_W = 12,
  parameter int IN_W  = 96,
  parameter int OUT_W = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // in_tdata: sat_index, sat_x, sat_y, sat_z, zero padding
  input  logic [IN_W-1:0]                in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: result_index, visible, dead, zero padding
  input  logic [OUT_W-1:0]               out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sev_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sev_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             failures,
  output int                             outstanding,
  output int                             results_seen,
  output int                             visible_seen,
  output int                             dead_seen
);
  import sev_pkg::*;

  // Wide enough for the squared dot product scaled by the sine fraction.
  localparam int WIDE = 192;
  typedef logic signed [WIDE-1:0] wide_t;
  localparam wide_t RADIUS_SQ = wide_t'(64'sd6378137) * wide_t'(64'sd6378137);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             visible;
    logic             dead;
  } verdict_t;

  // Local copy of the station registers
  logic signed [COORD_W-1:0] sta_x;
  logic signed [COORD_W-1:0] sta_y;
  logic signed [COORD_W-1:0] sta_z;
  logic signed [SINE_W-1:0]  min_sine;

  verdict_t pending_verdicts[$];

  // Elevation test against the current station, with roots avoided by
  // comparing squares once the signs of both sides are known.
  function automatic verdict_t predict_visibility(input logic [IDX_W-1:0] idx,
                                                  input logic signed [COORD_W-1:0] px,
                                                  input logic signed [COORD_W-1:0] py,
                                                  input logic signed [COORD_W-1:0] pz);
    wide_t sx, sy, sz, tx, ty, tz, dx, dy, dz, sn;
    wide_t sat2, st2, d2, dotp, dmag, lhs, rhs;
    verdict_t v;
    sx = px;
    sy = py;
    sz = pz;
    tx = sta_x;
    ty = sta_y;
    tz = sta_z;
    sn = min_sine;
    dx = sx - tx;
    dy = sy - ty;
    dz = sz - tz;
    sat2 = sx * sx + sy * sy + sz * sz;
    st2  = tx * tx + ty * ty + tz * tz;
    d2   = dx * dx + dy * dy + dz * dz;
    dotp = tx * dx + ty * dy + tz * dz;
    v.index   = idx;
    v.dead    = (sat2 < RADIUS_SQ);
    v.visible = 1'b0;
    // A station at the origin or a satellite on the station has no direction.
    if (!v.dead && st2 != 0 && d2 != 0) begin
      if (dotp >= 0 && sn <= 0) begin
        v.visible = 1'b1;
      end else if (dotp < 0 && sn > 0) begin
        v.visible = 1'b0;
      end else begin
        dmag = (dotp < 0) ? -dotp : dotp;
        lhs  = (dmag * dmag) <<< (2 * SINE_FRAC);
        rhs  = sn * sn * st2 * d2;
        v.visible = (dotp < 0) ? (lhs <= rhs) : (lhs >= rhs);
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin : scoreboard
    verdict_t want;
    verdict_t got;
    verdict_t fresh;
    if (!rst_n) begin
      sta_x    = STATION_X_RST;
      sta_y    = '0;
      sta_z    = '0;
      min_sine = '0;
      pending_verdicts.delete();
      failures     <= 0;
      outstanding  <= 0;
      results_seen <= 0;
      visible_seen <= 0;
      dead_seen    <= 0;
    end else begin
      // Result side: compare with the oldest waiting prediction.
      if (out_tvalid && out_tready) begin
        got.index   = out_tdata[IDX_W-1:0];
        got.visible = out_tdata[IDX_W];
        got.dead    = out_tdata[IDX_W+1];
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result: index %0d visible %0b dead %0b",
                   $time, got.index, got.visible, got.dead);
          failures <= failures + 1;
        end else begin
          want = pending_verdicts.pop_front();
          if (got.index != want.index || got.visible != want.visible ||
              got.dead != want.dead) begin
            $display("%0t: mismatch: expected index %0d visible %0b dead %0b,",
                     $time, want.index, want.visible, want.dead,
                     " got index %0d visible %0b dead %0b",
                     got.index, got.visible, got.dead);
            failures <= failures + 1;
          end
        end
        results_seen <= results_seen + 1;
        visible_seen <= visible_seen + int'(got.visible);
        dead_seen    <= dead_seen + int'(got.dead);
      end
      // Request side: predict with the settings in force before any write.
      if (in_tvalid && in_tready) begin
        fresh = predict_visibility(in_tdata[IDX_W-1:0],
                                   in_tdata[IDX_W +: COORD_W],
                                   in_tdata[IDX_W + COORD_W +: COORD_W],
                                   in_tdata[IDX_W + 2 * COORD_W +: COORD_W]);
        pending_verdicts.insert(pending_verdicts.size(), fresh);
      end
      // Register writes; unknown indexes leave everything as it is.
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_STATION_X: sta_x = cfg_data[COORD_W-1:0];
          CFG_STATION_Y: sta_y = cfg_data[COORD_W-1:0];
          CFG_STATION_Z: sta_z = cfg_data[COORD_W-1:0];
          CFG_MIN_SINE:  min_sine = cfg_data[SINE_W-1:0];
          default: ;
        endcase
      end
      outstanding <= pending_verdicts.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for satellite_elevation_visibility_test_core: clock, reset,
// request and register-write stimulus, output stalls and the verdict.
// Depends on sev_pkg, the core and sev_checker.
module tb;
  import sev_pkg::*;

  localparam int MAX_SATELLITES = 4096;
  localparam int IDX_W          = $clog2(MAX_SATELLITES);
  localparam int IN_W           = ((IDX_W + 3 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W          = ((IDX_W + 2 + 7) / 8) * 8;
  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_BURST     = 40;
  localparam int PHASE_ITEMS    = 12;
  localparam int NUM_SETTINGS   = 8;
  localparam int RADIUS         = 6378137;
  localparam int COORD_MAX      = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN      = -(2 ** (COORD_W - 1));

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int failures;
  int outstanding;
  int results_seen;
  int visible_seen;
  int dead_seen;

  // Pacing controls; the stall and hold settings are shared with the output process
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Station position currently programmed, used to aim requests near it
  int cur_x = RADIUS;
  int cur_y = 0;
  int cur_z = 0;

  // Station settings visited in turn: x, y, z and minimum elevation sine
  int set_x[NUM_SETTINGS]    = '{RADIUS, COORD_MAX, 0, 3194419, COORD_MIN, -4000000, 0, RADIUS};
  int set_y[NUM_SETTINGS]    = '{0, COORD_MIN, 0, 3194419, 0, 2500000, 0, 0};
  int set_z[NUM_SETTINGS]    = '{0, COORD_MAX, 0, 4487348, 0, -4200000, 0, 0};
  int set_sine[NUM_SETTINGS] = '{-32768, 32767, -100, 5690, 0, -11585, 0, 16384};

  satellite_elevation_visibility_test_core #(
    .MAX_SATELLITES(MAX_SATELLITES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sev_checker #(
    .IDX_W(IDX_W),
    .IN_W (IN_W),
    .OUT_W(OUT_W)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding),
    .results_seen(results_seen),
    .visible_seen(visible_seen),
    .dead_seen   (dead_seen)
  );

  // Clock
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Output side: random stalls, plus a long hold whenever one is requested.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Uniform value in [-span, span].
  function automatic int rand_coord(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Offer one request and return at the edge where it is taken. The valid
  // stays high so a following request can go out back to back.
  task automatic send_point(input int idx, input int x, input int y, input int z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({COORD_W'(z), COORD_W'(y), COORD_W'(x), IDX_W'(idx)});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random position: mostly orbits and points aimed along the station
  // vertical or close to the station, with raw bit patterns and dead points.
  task automatic send_random_point();
    int idx;
    int sel;
    int k;
    int x, y, z;
    idx = int'($urandom_range(MAX_SATELLITES - 1));
    sel = int'($urandom_range(99));
    k   = int'($urandom_range(12));
    if (sel < 25) begin
      x = int'($urandom());
      y = int'($urandom());
      z = int'($urandom());
    end else if (sel < 55) begin
      x = rand_coord(30000000);
      y = rand_coord(30000000);
      z = rand_coord(30000000);
    end else if (sel < 75) begin
      x = cur_x * k / 4 + rand_coord(2000000);
      y = cur_y * k / 4 + rand_coord(2000000);
      z = cur_z * k / 4 + rand_coord(2000000);
    end else if (sel < 85) begin
      x = cur_x + rand_coord(50000);
      y = cur_y + rand_coord(50000);
      z = cur_z + rand_coord(50000);
    end else if (sel < 95) begin
      x = rand_coord(3600000);
      y = rand_coord(3600000);
      z = rand_coord(3600000);
    end else begin
      case ($urandom_range(3))
        0: x = COORD_MAX;
        1: x = COORD_MIN;
        2: x = 0;
        default: x = cur_x;
      endcase
      y = ($urandom_range(1) == 0) ? COORD_MIN : cur_y;
      z = ($urandom_range(1) == 0) ? COORD_MAX : cur_z;
    end
    send_point(idx, x, y, z);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program the station and the minimum sine; optionally also poke an index
  // that names no register, which must change nothing.
  task automatic configure(input int x, input int y, input int z, input int sine,
                           input bit with_unused);
    write_reg(CFG_STATION_X, CFG_DATA_W'(x));
    write_reg(CFG_STATION_Y, CFG_DATA_W'(y));
    if (with_unused) begin
      write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_MIN_SINE + 1)),
                CFG_DATA_W'($urandom()));
    end
    write_reg(CFG_STATION_Z, CFG_DATA_W'(z));
    // Upper bits beyond the sine width carry junk on purpose.
    write_reg(CFG_MIN_SINE, {(CFG_DATA_W - SINE_W)'($urandom()), SINE_W'(sine)});
    cfg_valid <= 1'b0;
    cur_x = x;
    cur_y = y;
    cur_z = z;
  endtask

  // Stop offering requests until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int s;
    int ph;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests against the reset station with a zero minimum sine.
    send_point(0, 0, 0, 0);
    send_point(MAX_SATELLITES - 1, RADIUS, 0, 0);
    send_point(1, RADIUS - 1, 0, 0);
    send_point(2, 20000000, 0, 0);
    send_point(3, -20000000, 0, 0);
    send_point(4, RADIUS, 15000000, 0);
    send_point(5, RADIUS - 1, 15000000, 0);
    send_point(6, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(7, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(8, COORD_MAX, COORD_MIN, 0);
    send_point(9, 0, 0, COORD_MAX);
    send_point(10, RADIUS, 0, 1);

    set_x[6]    = rand_coord(7000000);
    set_y[6]    = rand_coord(7000000);
    set_z[6]    = rand_coord(7000000);
    set_sine[6] = int'($urandom_range(65535)) - 32768;

    for (s = 0; s < NUM_SETTINGS; s++) begin
      wait_drained();
      configure(set_x[s], set_y[s], set_z[s], set_sine[s], s % 2 == 0);
      if (s == 0) begin
        // Straight down through the Earth sits exactly on a sine of minus one.
        send_point(11, -20000000, 0, 0);
        send_point(12, RADIUS, 0, 0);
        send_point(13, 0, 0, 0);
      end
      if (s == 3) begin
        // Long output hold while requests keep coming, so the input backs up.
        recv_stall_pct <= 0;
        send_idle_pct = 0;
        hold_seq <= hold_seq + 1;
        repeat (HOLD_BURST) send_random_point();
      end
      for (ph = 0; ph < 4; ph++) begin
        case (ph)
          0: begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
          end
          1: begin
            send_idle_pct = 55;
            recv_stall_pct <= 0;
          end
          2: begin
            send_idle_pct = 0;
            recv_stall_pct <= 55;
          end
          default: begin
            send_idle_pct = 10;
            recv_stall_pct <= 10;
          end
        endcase
        repeat (PHASE_ITEMS) send_random_point();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d results (%0d visible, %0d dead) over %0d station settings,",
             results_seen, visible_seen, dead_seen, NUM_SETTINGS + 1);
    $display("with idle and stall phases, a long output hold and full drains.");
    if (failures == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timeout with %0d results outstanding.", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sev_pkg.sv
rtl/core/sev_front.sv
rtl/core/sev_cmp.sv
rtl/core/satellite_elevation_visibility_test_core.sv
sim/sev_checker.sv
sim/tb.sv
